// ----- sv/assert_macros.svh -----
// Assertion macros shared by the hue rotation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/hsl_pkg.sv -----
// Shared types, constants and helpers of the HSL hue rotation block.
`default_nettype none

package hsl_pkg;

    // Fixed-point format: values in units of 2^-FRAC_BITS
    localparam int FRAC_BITS   = 16;
    localparam int VW          = FRAC_BITS + 1;   // 0 .. ONE
    localparam int SW          = FRAC_BITS + 2;   // 0 .. 2*ONE
    localparam int DEG_W       = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [VW-1:0] FX_ONE        = VW'(2**FRAC_BITS);
    localparam logic [VW-1:0] FX_THIRD      = VW'((2**FRAC_BITS) / 3);
    localparam logic [VW-1:0] FX_TWO_THIRDS = VW'((2 * (2**FRAC_BITS)) / 3);
    localparam logic [SW-1:0] FX_TWO        = SW'(2 * (2**FRAC_BITS));

    // Reciprocal of 255 for the byte to fraction scaling
    localparam int M255_K = 16;
    localparam int M255_W = FRAC_BITS + 9;
    localparam logic [M255_W-1:0] M255 =
        M255_W'((64'd1 << (FRAC_BITS + M255_K)) / 64'd255);

    // Reciprocal of 3 (division by 6 is a shift then a division by 3)
    localparam int M3_K = FRAC_BITS + 2;
    localparam logic [VW-1:0] M3 = VW'((64'd1 << M3_K) / 64'd3);

    // Reciprocal of 360 for the degree to fraction scaling
    localparam int MA_K = DEG_W;
    localparam logic [VW-1:0] MA = VW'((64'd1 << (FRAC_BITS + MA_K)) / 64'd360);

    localparam logic [DEG_W-1:0] DEG_FULL    = DEG_W'(360);
    localparam logic [DEG_W-1:0] SHIFT_RESET = DEG_W'(180);

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    // Which channel holds the maximum (red wins ties, then green)
    typedef enum logic [1:0] {
        MAX_R,
        MAX_G,
        MAX_B
    } t_maxch;

    // Hue segment of the back conversion
    typedef enum logic [1:0] {
        SEG_RAMP_UP,
        SEG_TOP,
        SEG_RAMP_DN,
        SEG_BOTTOM
    } t_seg;

    // Classified pixel handed from front to back
    typedef struct packed {
        t_maxch               maxch;
        logic [FRAC_BITS-1:0] ya;    // (max - chan A) / 2
        logic [FRAC_BITS-1:0] qa;    // ya / 3 estimate, may be one low
        logic [FRAC_BITS-1:0] yb;
        logic [FRAC_BITS-1:0] qb;
        logic [VW-1:0]        del;
        logic [SW-1:0]        sum;
    } t_cls;

    // Side data traveling beside the dividers
    typedef struct packed {
        t_maxch        maxch;
        logic          grey;
        logic          lo;
        logic [VW-1:0] l;
    } t_side;

    // c * ONE / 255, truncated: reciprocal multiply plus one correction
    function automatic logic [VW-1:0] fx_of_byte(input logic [7:0] c);
        logic [M255_W+7:0]    p;
        logic [FRAC_BITS+7:0] num;
        logic [FRAC_BITS+7:0] qx;
        logic [FRAC_BITS+7:0] rem;
        logic [VW-1:0]        q;
        p   = (M255_W+8)'(c) * (M255_W+8)'(M255);
        q   = VW'(p >> M255_K);
        num = {c, {FRAC_BITS{1'b0}}};
        qx  = (FRAC_BITS+8)'(q);
        rem = num - ((qx << 8) - qx);
        if (rem >= (FRAC_BITS+8)'(255)) begin
            q = q + VW'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hsl_front.sv -----
// Front end: takes pixels, scales channels and classifies max/min.
`default_nettype none

module hsl_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire hsl_pkg::t_pix_in i_pixel,
    output logic                 o_push,
    output hsl_pkg::t_cls        o_cls,
    input  wire logic            i_full
);

    logic                       r_valid;
    logic [hsl_pkg::VW-1:0]     r_vr;
    logic [hsl_pkg::VW-1:0]     r_vg;
    logic [hsl_pkg::VW-1:0]     r_vb;
    logic                       take;
    logic [hsl_pkg::VW-1:0]     mx;
    logic [hsl_pkg::VW-1:0]     mn;
    logic [hsl_pkg::VW-1:0]     va;
    logic [hsl_pkg::VW-1:0]     vb;
    logic [hsl_pkg::VW-1:0]     da;
    logic [hsl_pkg::VW-1:0]     db;
    logic [2*hsl_pkg::VW-1:0]   pa;
    logic [2*hsl_pkg::VW-1:0]   pb;
    hsl_pkg::t_maxch            maxch;

    assign o_ready = !r_valid || !i_full;
    assign take    = i_valid && o_ready;
    assign o_push  = r_valid && !i_full;

    // Stage register: scaled channels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_vr <= hsl_pkg::fx_of_byte(i_pixel.red_in);
            r_vg <= hsl_pkg::fx_of_byte(i_pixel.green_in);
            r_vb <= hsl_pkg::fx_of_byte(i_pixel.blue_in);
        end
    end

    // Max/min and the two non-trivial hue terms for the max channel
    always_comb begin
        if (r_vr >= r_vg && r_vr >= r_vb) begin
            maxch = hsl_pkg::MAX_R;
            mx    = r_vr;
            va    = r_vb;
            vb    = r_vg;
        end else if (r_vg >= r_vb) begin
            maxch = hsl_pkg::MAX_G;
            mx    = r_vg;
            va    = r_vr;
            vb    = r_vb;
        end else begin
            maxch = hsl_pkg::MAX_B;
            mx    = r_vb;
            va    = r_vg;
            vb    = r_vr;
        end
        mn = r_vr;
        if (r_vg < mn) mn = r_vg;
        if (r_vb < mn) mn = r_vb;
        da = mx - va;
        db = mx - vb;
        pa = (2*hsl_pkg::VW)'(da >> 1) * (2*hsl_pkg::VW)'(hsl_pkg::M3);
        pb = (2*hsl_pkg::VW)'(db >> 1) * (2*hsl_pkg::VW)'(hsl_pkg::M3);
        o_cls.maxch = maxch;
        o_cls.ya    = hsl_pkg::FRAC_BITS'(da >> 1);
        o_cls.qa    = hsl_pkg::FRAC_BITS'(pa >> hsl_pkg::M3_K);
        o_cls.yb    = hsl_pkg::FRAC_BITS'(db >> 1);
        o_cls.qb    = hsl_pkg::FRAC_BITS'(pb >> hsl_pkg::M3_K);
        o_cls.del   = mx - mn;
        o_cls.sum   = hsl_pkg::SW'(mx) + hsl_pkg::SW'(mn);
    end

endmodule

`default_nettype wire

// ----- sv/hsl_fifo.sv -----
// Short queue of classified pixels between front and back.
`default_nettype none
`include "assert_macros.svh"

module hsl_fifo #(
    parameter int DEPTH = hsl_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hsl_pkg::t_cls i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output hsl_pkg::t_cls      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsl_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count overflow")
    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

`default_nettype wire

// ----- sv/hsl_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, fraction result.
`default_nettype none

module hsl_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [hsl_pkg::VW-1:0] i_num,   // must be below 2 * i_den
    input  wire logic [hsl_pkg::VW-1:0] i_den,
    output logic [hsl_pkg::VW-1:0]      o_quo    // i_num * ONE / i_den
);

    localparam int W = hsl_pkg::VW;

    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_den [W];
    logic [W-1:0] r_quo [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W:0]   rin;
        logic [W:0]   dif;
        logic [W-1:0] dsrc;
        logic [W-1:0] qsrc;
        logic         ge;

        // Partial remainder entering this stage
        if (k == 0) begin : g_first
            assign rin  = {1'b0, i_num};
            assign dsrc = i_den;
            assign qsrc = '0;
        end else begin : g_next
            assign rin  = {r_rem[k-1], 1'b0};
            assign dsrc = r_den[k-1];
            assign qsrc = r_quo[k-1];
        end

        assign ge  = (rin >= {1'b0, dsrc});
        assign dif = rin - {1'b0, dsrc};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? W'(dif) : W'(rin);
                r_den[k] <= dsrc;
                r_quo[k] <= qsrc | (W'(ge) << (W - 1 - k));
            end
        end
    end

    assign o_quo = r_quo[W-1];

endmodule

`default_nettype wire

// ----- sv/hsl_back.sv -----
// Back end: saturation and hue divisions, hue shift, HSL to RGB, output register.
`default_nettype none
`include "assert_macros.svh"

module hsl_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire hsl_pkg::t_cls                 i_head,
    output logic                               o_pop,
    input  wire logic [hsl_pkg::FRAC_BITS-1:0] i_angle,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output hsl_pkg::t_pix_out                  o_pixel
);

    localparam int N  = hsl_pkg::FRAC_BITS;
    localparam int VW = hsl_pkg::VW;
    localparam int SW = hsl_pkg::SW;

    logic                en;

    // stage 0 (ahead of the dividers)
    logic [N+1:0]        tri_a;
    logic [N+1:0]        tri_b;
    logic [N-1:0]        qa_c;
    logic [N-1:0]        qb_c;
    logic [VW-1:0]       half;
    logic [VW-1:0]       na;
    logic [VW-1:0]       nb;
    logic [VW-1:0]       den_s;
    logic [VW-1:0]       den_d;
    hsl_pkg::t_side      side0;
    logic [VW-1:0]       quo_s;
    logic [VW-1:0]       quo_a;
    logic [VW-1:0]       quo_b;
    hsl_pkg::t_side      r_side [VW];
    logic                r_dv [VW];

    // stage 1
    hsl_pkg::t_side      sd;
    logic [VW-1:0]       off;
    logic signed [VW+1:0] hs;
    logic [VW-1:0]       h1;
    logic [VW:0]         h2w;
    logic [VW-1:0]       s1;
    logic [VW:0]         ma;
    logic [VW:0]         mb;
    logic                r1_valid;
    logic [VW-1:0]       r1_h;
    logic [VW-1:0]       r1_s;
    logic [VW-1:0]       r1_l;
    logic                r1_lo;
    logic [2*VW+1:0]     r1_prod;

    // stage 2
    logic [VW:0]         pm;
    logic signed [VW+2:0] v2;
    logic signed [VW+2:0] v1;
    logic signed [VW+2:0] dsg;
    logic [VW+1:0]       diff;
    logic [VW:0]         hw;
    logic signed [VW+1:0] hbs;
    logic [VW-1:0]       hue [3];
    hsl_pkg::t_seg       seg [3];
    logic [VW+2:0]       tv [3];
    logic                r2_valid;
    hsl_pkg::t_seg       r2_seg [3];
    logic [2*VW+4:0]     r2_prod [3];
    logic signed [VW+2:0] r2_v1;
    logic signed [VW+2:0] r2_v2;
    logic [VW-1:0]       r2_l;
    logic                r2_sz;

    // stage 3 / output
    logic signed [VW+2:0] xv [3];
    logic [7:0]          byt [3];
    logic                r_out_valid;
    logic                r_out_grey;
    hsl_pkg::t_pix_out   r_out;

    // hue segment of a wrapped hue
    function automatic hsl_pkg::t_seg seg_of(input logic [VW-1:0] h);
        logic [VW+2:0] h6;
        logic [VW:0]   h2;
        logic [VW+1:0] h3;
        h6 = (VW+3)'(h) * (VW+3)'(6);
        h2 = {h, 1'b0};
        h3 = (VW+2)'(h) * (VW+2)'(3);
        if (h6 < (VW+3)'(hsl_pkg::FX_ONE)) begin
            return hsl_pkg::SEG_RAMP_UP;
        end else if (h2 < (VW+1)'(hsl_pkg::FX_ONE)) begin
            return hsl_pkg::SEG_TOP;
        end else if (h3 < (VW+2)'(2) * (VW+2)'(hsl_pkg::FX_ONE)) begin
            return hsl_pkg::SEG_RAMP_DN;
        end else begin
            return hsl_pkg::SEG_BOTTOM;
        end
    endfunction

    // fraction to byte with rounding bias and clamp
    function automatic logic [7:0] to_byte(input logic signed [VW+2:0] x);
        logic [VW+11:0] y;
        logic [VW+11:0] p;
        y = ((VW+12)'(x) << 8) - (VW+12)'(x) + (VW+12)'(255);
        p = y >> N;
        if (x < 0) begin
            return 8'd0;
        end else if (p > (VW+12)'(255)) begin
            return 8'd255;
        end else begin
            return p[7:0];
        end
    endfunction

    // Global advance: the whole back stalls only when the output is held
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    // Stage 0: finish the divisions by 6, set up dividers
    always_comb begin
        tri_a = (N+2)'(i_head.ya) - (N+2)'(i_head.qa) * (N+2)'(3);
        tri_b = (N+2)'(i_head.yb) - (N+2)'(i_head.qb) * (N+2)'(3);
        qa_c  = i_head.qa + N'(tri_a >= (N+2)'(3));
        qb_c  = i_head.qb + N'(tri_b >= (N+2)'(3));
        half  = i_head.del >> 1;
        na    = VW'(qa_c) + half;
        nb    = VW'(qb_c) + half;
        side0.maxch = i_head.maxch;
        side0.grey  = (i_head.del == '0);
        side0.lo    = (i_head.sum < SW'(hsl_pkg::FX_ONE));
        side0.l     = VW'(i_head.sum >> 1);
        if (side0.grey) begin
            den_s = VW'(1);
            den_d = VW'(1);
        end else begin
            den_s = side0.lo ? VW'(i_head.sum) : VW'(hsl_pkg::FX_TWO - i_head.sum);
            den_d = i_head.del;
        end
    end

    hsl_div u_div_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_head.del),
        .i_den (den_s),
        .o_quo (quo_s)
    );

    hsl_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (side0.grey ? '0 : na),
        .i_den (den_d),
        .o_quo (quo_a)
    );

    hsl_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (side0.grey ? '0 : nb),
        .i_den (den_d),
        .o_quo (quo_b)
    );

    // Side data and valid line matching divider latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VW; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= o_pop;
            for (int k = 1; k < VW; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side0;
            for (int k = 1; k < VW; k++) r_side[k] <= r_side[k-1];
        end
    end

    // Stage 1: hue, shift, wrap; lightness product
    always_comb begin
        sd = r_side[VW-1];
        case (sd.maxch)
            hsl_pkg::MAX_R: off = '0;
            hsl_pkg::MAX_G: off = hsl_pkg::FX_THIRD;
            hsl_pkg::MAX_B: off = hsl_pkg::FX_TWO_THIRDS;
            default:        off = '0;
        endcase
        hs = $signed({2'b00, off}) + $signed({2'b00, quo_a}) - $signed({2'b00, quo_b});
        if (hs < 0) begin
            hs = hs + $signed({2'b00, hsl_pkg::FX_ONE});
        end else if (hs > $signed({2'b00, hsl_pkg::FX_ONE})) begin
            hs = hs - $signed({2'b00, hsl_pkg::FX_ONE});
        end
        h1  = sd.grey ? '0 : VW'(hs);
        h2w = {1'b0, h1} + (VW+1)'(i_angle);
        if (h2w > (VW+1)'(hsl_pkg::FX_ONE)) begin
            h2w = h2w - (VW+1)'(hsl_pkg::FX_ONE);
        end
        s1 = sd.grey ? '0 : quo_s;
        if (sd.lo) begin
            ma = (VW+1)'(sd.l);
            mb = (VW+1)'(hsl_pkg::FX_ONE) + (VW+1)'(s1);
        end else begin
            ma = (VW+1)'(s1);
            mb = (VW+1)'(sd.l);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= r_dv[VW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_h    <= VW'(h2w);
            r1_s    <= s1;
            r1_l    <= sd.l;
            r1_lo   <= sd.lo;
            r1_prod <= (2*VW+2)'(ma) * (2*VW+2)'(mb);
        end
    end

    // Stage 2: v1/v2, per-channel hue segment and ramp product
    always_comb begin
        pm = (VW+1)'(r1_prod >> N);
        if (r1_lo) begin
            v2 = $signed((VW+3)'(pm));
        end else begin
            v2 = $signed((VW+3)'(r1_l)) + $signed((VW+3)'(r1_s)) - $signed((VW+3)'(pm));
        end
        v1   = $signed((VW+3)'(r1_l) << 1) - v2;
        dsg  = v2 - v1;
        diff = (VW+2)'(dsg);
        hw   = (VW+1)'(r1_h) + (VW+1)'(hsl_pkg::FX_THIRD);
        if (hw > (VW+1)'(hsl_pkg::FX_ONE)) begin
            hw = hw - (VW+1)'(hsl_pkg::FX_ONE);
        end
        hbs = $signed((VW+2)'(r1_h)) - $signed((VW+2)'(hsl_pkg::FX_THIRD));
        if (hbs < 0) begin
            hbs = hbs + $signed((VW+2)'(hsl_pkg::FX_ONE));
        end
        hue[0] = VW'(hw);
        hue[1] = r1_h;
        hue[2] = VW'(hbs);
        for (int c = 0; c < 3; c++) begin
            seg[c] = seg_of(hue[c]);
            case (seg[c])
                hsl_pkg::SEG_RAMP_UP: tv[c] = (VW+3)'(hue[c]) * (VW+3)'(6);
                hsl_pkg::SEG_RAMP_DN: tv[c] = (VW+3)'(hsl_pkg::FX_TWO_THIRDS - hue[c])
                                             * (VW+3)'(6);
                default:              tv[c] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r2_seg[c]  <= seg[c];
                r2_prod[c] <= (2*VW+5)'(diff) * (2*VW+5)'(tv[c]);
            end
            r2_v1 <= v1;
            r2_v2 <= v2;
            r2_l  <= r1_l;
            r2_sz <= (r1_s == '0);
        end
    end

    // Stage 3: channel value and byte conversion
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r2_seg[c])
                hsl_pkg::SEG_RAMP_UP,
                hsl_pkg::SEG_RAMP_DN: xv[c] = r2_v1 + $signed((VW+3)'(r2_prod[c] >> N));
                hsl_pkg::SEG_TOP:     xv[c] = r2_v2;
                default:              xv[c] = r2_v1;
            endcase
            if (r2_sz) begin
                xv[c] = $signed((VW+3)'(r2_l));
            end
            byt[c] = to_byte(xv[c]);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.red_out   <= byt[0];
            r_out.green_out <= byt[1];
            r_out.blue_out  <= byt[2];
            r_out_grey      <= r2_sz;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

    `ASSERT_IMPLIES(a_grey_equal, i_clk, i_rst_n, r_out_valid && r_out_grey, (r_out.red_out == r_out.green_out) && (r_out.green_out == r_out.blue_out), "unsaturated pixel with unequal channels")
    `ASSERT_IMPLIES(a_pop_advance, i_clk, i_rst_n, o_pop, en && !r_dv[0] || en, "pop while back stalled")

endmodule

`default_nettype wire

// ----- sv/hsl_hue_rotate_pixel.sv -----
// Pixels pass the front register, queue, dividers, stages 1 and 2, output register.
// Throughput: one pixel per clock unless held; the 17-stage dividers set the latency.
// A 4-entry queue between front and back lets input keep flowing while output stalls.
// Reset (synchronous, active low) clears all valid state and sets the hue shift to 180.
// A shift write passes r_ang_raw and r_ang_d before the angle settles in r_angle.
`default_nettype none

module hsl_hue_rotate_pixel #(
    parameter int QUEUE_DEPTH = hsl_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire hsl_pkg::t_pix_in           i_pixel,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output hsl_pkg::t_pix_out               o_pixel,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [hsl_pkg::DEG_W-1:0]  i_cfg_data
);

    localparam int N  = hsl_pkg::FRAC_BITS;
    localparam int DW = hsl_pkg::DEG_W;

    logic [DW-1:0]     r_shift;
    logic [DW-1:0]     r_ang_d;
    logic [N-1:0]      r_ang_raw;
    logic [N-1:0]      r_angle;
    logic [DW-1:0]     n_ang_d;
    logic [DW+N:0]     ang_prod;
    logic [DW+N-1:0]   ang_rem;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    hsl_pkg::t_cls     cls;
    hsl_pkg::t_cls     head;

    assign o_cfg_ready = 1'b1;

    // Hue shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= hsl_pkg::SHIFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_shift <= i_cfg_data;
        end
    end

    // Degrees to fraction of a turn: reciprocal multiply, then one correction
    always_comb begin
        n_ang_d  = (r_shift >= hsl_pkg::DEG_FULL) ? r_shift - hsl_pkg::DEG_FULL : r_shift;
        ang_prod = (DW+N+1)'(n_ang_d) * (DW+N+1)'(hsl_pkg::MA);
        ang_rem  = {r_ang_d, {N{1'b0}}} - (DW+N)'(r_ang_raw) * (DW+N)'(hsl_pkg::DEG_FULL);
    end

    always_ff @(posedge i_clk) begin
        r_ang_d   <= n_ang_d;
        r_ang_raw <= N'(ang_prod >> hsl_pkg::MA_K);
        r_angle   <= r_ang_raw + N'(ang_rem >= (DW+N)'(hsl_pkg::DEG_FULL));
    end

    hsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_push  (push),
        .o_cls   (cls),
        .i_full  (full)
    );

    hsl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    hsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .i_angle (r_angle),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_pixel)
    );

endmodule

`default_nettype wire

// ----- verif/hsl_hue_rotate_pixel_test.sv -----
// Testbench for the HSL hue rotation pixel block: self-checking, with random stalls.
`default_nettype none

module hsl_hue_rotate_pixel_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE        = longint'(1) << hsl_pkg::FRAC_BITS;
    localparam longint HALF       = ONE / 2;
    localparam longint THIRD      = ONE / 3;
    localparam longint TWO_THIRDS = (2 * ONE) / 3;
    localparam int     DRAIN_WAIT = 30;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    hsl_pkg::t_pix_in          i_pixel;
    logic                      o_valid;
    logic                      i_ready;
    hsl_pkg::t_pix_out         o_pixel;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [hsl_pkg::DEG_W-1:0] i_cfg_data;

    // Predictor copy of the hue shift register
    logic [hsl_pkg::DEG_W-1:0] shift_deg;
    hsl_pkg::t_pix_out         expected_pixels[$];
    int                        mismatch_count;
    bit                        idle_enable;
    int                        ready_holdoff;

    hsl_hue_rotate_pixel u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel     (o_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall limit
    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // Fraction product, truncated toward zero
    function automatic longint frac_mul(longint a, longint b);
        bit     neg;
        longint m;
        neg = (a < 0) != (b < 0);
        m   = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> hsl_pkg::FRAC_BITS;
        return neg ? -m : m;
    endfunction

    // Four-segment hue-to-channel rule
    function automatic longint hue_channel(longint v1, longint v2, longint h);
        if (h < 0) h += ONE;
        if (h > ONE) h -= ONE;
        if (6 * h < ONE) return v1 + frac_mul(v2 - v1, 6 * h);
        if (2 * h < ONE) return v2;
        if (3 * h < 2 * ONE) return v1 + frac_mul(v2 - v1, (TWO_THIRDS - h) * 6);
        return v1;
    endfunction

    function automatic logic [7:0] frac_to_byte(longint x);
        longint p;
        if (x < 0) return 8'd0;
        p = (x * 255 + 255) >>> hsl_pkg::FRAC_BITS;
        return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    // Rotate the hue of one pixel by the given shift
    function automatic hsl_pkg::t_pix_out rotate_hue(hsl_pkg::t_pix_in px,
                                                     logic [hsl_pkg::DEG_W-1:0] deg_in);
        longint            vr, vg, vb, mx, mn, del, l, s, h, dr, dg, db, v1, v2;
        int                deg;
        hsl_pkg::t_pix_out r;
        vr  = (longint'(px.red_in) << hsl_pkg::FRAC_BITS) / 255;
        vg  = (longint'(px.green_in) << hsl_pkg::FRAC_BITS) / 255;
        vb  = (longint'(px.blue_in) << hsl_pkg::FRAC_BITS) / 255;
        mx  = vr;
        mn  = vr;
        deg = deg_in;
        if (vg > mx) mx = vg;
        if (vb > mx) mx = vb;
        if (vg < mn) mn = vg;
        if (vb < mn) mn = vb;
        del = mx - mn;
        l   = (mx + mn) / 2;
        if (del == 0) begin
            h = 0;
            s = 0;
        end else begin
            if (l < HALF) s = (del * ONE) / (mx + mn);
            else s = (del * ONE) / (2 * ONE - mx - mn);
            dr = (((mx - vr) / 6 + del / 2) * ONE) / del;
            dg = (((mx - vg) / 6 + del / 2) * ONE) / del;
            db = (((mx - vb) / 6 + del / 2) * ONE) / del;
            if (vr == mx) h = db - dg;
            else if (vg == mx) h = THIRD + dr - db;
            else h = TWO_THIRDS + dg - dr;
            if (h < 0) h += ONE;
            if (h > ONE) h -= ONE;
        end
        if (deg >= 360) deg -= 360;
        h += (longint'(deg) * ONE) / 360;
        if (h > ONE) h -= ONE;
        if (s == 0) begin
            r.red_out   = frac_to_byte(l);
            r.green_out = r.red_out;
            r.blue_out  = r.red_out;
        end else begin
            if (l < HALF) v2 = frac_mul(l, ONE + s);
            else v2 = (l + s) - frac_mul(s, l);
            v1 = 2 * l - v2;
            r.red_out   = frac_to_byte(hue_channel(v1, v2, h + THIRD));
            r.green_out = frac_to_byte(hue_channel(v1, v2, h));
            r.blue_out  = frac_to_byte(hue_channel(v1, v2, h - THIRD));
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    // Input and config transactions feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) shift_deg <= i_cfg_data;
            if (i_valid && o_ready) expected_pixels.push_back(rotate_hue(i_pixel, shift_deg));
        end
    end

    // Output transactions are checked against the oldest prediction
    always @(posedge i_clk) begin
        hsl_pkg::t_pix_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no pixel pending", $realtime);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel.red_out !== want.red_out)
                    report_mismatch("red_out", o_pixel.red_out, want.red_out);
                if (o_pixel.green_out !== want.green_out)
                    report_mismatch("green_out", o_pixel.green_out, want.green_out);
                if (o_pixel.blue_out !== want.blue_out)
                    report_mismatch("blue_out", o_pixel.blue_out, want.blue_out);
            end
        end
    end

    // Ready: long holdoff on request, else random stall bursts while idle_enable
    initial begin
        int burst;
        burst   = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_holdoff > 0) begin
                ready_holdoff--;
                i_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 12) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one pixel, with an optional gap first; valid stays high afterwards
    task automatic send_pixel(hsl_pkg::t_pix_in px);
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    task automatic send_rgb(int r, int g, int b);
        hsl_pkg::t_pix_in px;
        px.red_in   = 8'(r);
        px.green_in = 8'(g);
        px.blue_in  = 8'(b);
        send_pixel(px);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Register write while the block is idle
    task automatic write_shift(logic [hsl_pkg::DEG_W-1:0] deg);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= deg;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    // Random pixel: greys, near greys, red/blue extremes or fully random
    function automatic hsl_pkg::t_pix_in random_pixel();
        hsl_pkg::t_pix_in px;
        int               base;
        px = hsl_pkg::t_pix_in'(24'($urandom));
        case ($urandom_range(0, 5))
            0: begin
                px.green_in = px.red_in;
                px.blue_in  = px.red_in;
            end
            1: begin
                base        = $urandom_range(1, 254);
                px.red_in   = 8'(base + $urandom_range(0, 1));
                px.green_in = 8'(base - $urandom_range(0, 1));
                px.blue_in  = 8'(base);
            end
            2: begin
                px.red_in   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                px.blue_in  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: ;
        endcase
        return px;
    endfunction

    // Greys, primaries, secondaries and channel extremes at the reset shift
    task automatic test_directed();
        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(128, 128, 128);
        send_rgb(1, 1, 1);
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(255, 254, 254);
        send_rgb(0, 1, 0);
        send_rgb(200, 50, 100);
        send_rgb(10, 240, 120);
        send_rgb(170, 85, 85);
        send_rgb(254, 255, 1);
        send_rgb(127, 128, 129);
        send_rgb(64, 32, 16);
    endtask

    // Shift register extremes, including values above a full turn
    task automatic test_shift_settings();
        int shifts[7] = '{0, 359, 360, 511, 1, 120, 180};
        foreach (shifts[k]) begin
            write_shift(hsl_pkg::DEG_W'(shifts[k]));
            send_rgb(255, 0, 0);
            send_rgb(0, 0, 255);
            send_rgb(30, 200, 90);
            send_rgb(77, 77, 77);
            repeat (6) send_pixel(random_pixel());
        end
    endtask

    // Output held off long enough to fill the queue and stall the input
    task automatic test_output_holdoff();
        @(negedge i_clk);
        ready_holdoff = 80;
        repeat (40) send_pixel(random_pixel());
    endtask

    // Sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (10) send_pixel(random_pixel());
        wait_drained();
        repeat (10) send_pixel(random_pixel());
    endtask

    // Random pixels over several shift settings; the last stretch runs at full rate
    task automatic test_random_stream();
        for (int ph = 0; ph < 6; ph++) begin
            write_shift(hsl_pkg::DEG_W'($urandom_range(0, 511)));
            if (ph == 5) idle_enable = 1'b0;
            repeat (200) send_pixel(random_pixel());
        end
    endtask

    initial begin
        mismatch_count = 0;
        idle_enable    = 1'b1;
        ready_holdoff  = 0;
        shift_deg      = hsl_pkg::SHIFT_RESET;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_pixel        = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_shift_settings();
        test_output_holdoff();
        test_sender_pause();
        test_random_stream();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- hsl_hue_rotate_pixel.f -----
+incdir+sv
sv/hsl_pkg.sv
sv/hsl_front.sv
sv/hsl_fifo.sv
sv/hsl_div.sv
sv/hsl_back.sv
sv/hsl_hue_rotate_pixel.sv
verif/hsl_hue_rotate_pixel_test.sv
